// ----- rtl/core/pmd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_pkg: shared types and constants of the PIR motion detector
// Field widths, register indexes, register reset values and the stage
// control bundle that travels between the pipeline modules.
// ----------------------------------------------------------------------------
package pmd_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int ACC_W     = 32;
	localparam int SHIFT_W   = 4;
	localparam int THR_W     = 15;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 15;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_SHIFT     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 1'b1;

	localparam logic [SHIFT_W-1:0] FILTER_SHIFT_RST     = 4'd4;
	localparam logic [THR_W-1:0]   MOTION_THRESHOLD_RST = 15'd100;

	// pipeline advance plus the valid bit of the stage being handed over
	typedef struct packed {
		logic adv;
		logic vld;
	} stage_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/pmd_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_cell: one history cell
// Holds one filtered value and hands it to its neighbor on every shift.
// ----------------------------------------------------------------------------
module pmd_cell
	import pmd_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       shift_en,
	input  wire logic signed [SAMPLE_W-1:0] d,
	output logic signed [SAMPLE_W-1:0]      q
);

	logic signed [SAMPLE_W-1:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (shift_en) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule
`default_nettype wire

// ----- rtl/core/pmd_history.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_history: chain of history cells with running sum
// Shift the new filtered value into the chain, drop the oldest off the end
// and keep the exact sum of all cells.
// ----------------------------------------------------------------------------
module pmd_history
	import pmd_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int SUM_W = 20
)(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire stage_ctl_t                 ctl,
	input  wire logic signed [SAMPLE_W-1:0] filt,
	output logic signed [SUM_W-1:0]         sum
);

	logic signed [SAMPLE_W-1:0] tap [DEPTH];
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SUM_W-1:0]    sum_next;
	logic                       shift_en;

	assign shift_en = ctl.adv & ctl.vld;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			pmd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.d        (filt),
				.q        (tap[i])
			);
		end else begin : g_body
			pmd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.d        (tap[i-1]),
				.q        (tap[i])
			);
		end
	end

	// oldest value leaves, newest enters
	assign sum_next = sum_q
		- SUM_W'(tap[DEPTH-1])
		+ SUM_W'(filt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (shift_en) begin
			sum_q <= sum_next;
		end
	end

	assign sum = sum_q;

endmodule
`default_nettype wire

// ----- rtl/core/pmd_avg_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_avg_div: divide the running sum by the history depth
// Sign-magnitude multiply by a rounded-up reciprocal; the quotient is exact
// and truncates toward zero.
// ----------------------------------------------------------------------------
module pmd_avg_div
	import pmd_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int SUM_W = 20
)(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire stage_ctl_t             ctl,
	input  wire logic signed [SUM_W-1:0] sum,
	output logic signed [SAMPLE_W-1:0]  avg
);

	localparam int DepthLog = $clog2(DEPTH);
	localparam int K        = SUM_W + DepthLog;
	localparam int MW       = SUM_W + 2;
	localparam int PW       = SUM_W + MW;
	localparam int QW       = SAMPLE_W + 1;
	localparam longint unsigned RecipFull =
		((64'd1 << K) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
	localparam logic [MW-1:0] Recip = RecipFull[MW-1:0];

	logic             neg;
	logic [SUM_W-1:0] mag;
	logic [PW-1:0]    prod_s3;
	logic             neg_s3;
	logic [QW-1:0]    quot;
	logic [QW-1:0]    quot_signed;

	assign neg = sum[SUM_W-1];
	assign mag = neg ? SUM_W'(-sum) : SUM_W'(sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_s3 <= 1'b0;
		end else if (ctl.adv & ctl.vld) begin
			neg_s3 <= neg;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv & ctl.vld) begin
			prod_s3 <= PW'(mag) * PW'(Recip);
		end
	end

	assign quot        = prod_s3[K +: QW];
	assign quot_signed = neg_s3 ? (~quot + QW'(1)) : quot;
	assign avg         = quot_signed[SAMPLE_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/core/pir_motion_detector_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pir_motion_detector_unit: PIR motion detector
// Leaky-integrator smoothing, moving average over AVERAGE_DEPTH values and
// deviation threshold, as a four-stage pipeline around a chain of cells.
// ----------------------------------------------------------------------------
// The block takes one signed 16-bit sample per transfer and returns one
// result per sample: the integrator output (filtered), the mean of the last
// AVERAGE_DEPTH filtered values truncated toward zero (average), and a
// motion flag that is set when filtered lies strictly outside
// average +/- motion_threshold. It sustains one transfer per clock cycle
// while no result is held at the output; a sample passes through the four
// pipeline stages (integrator update, history shift and sum, reciprocal
// multiply, compare and output register), the first of which loads at the
// accepting edge. The whole pipeline holds while a result waits at the
// output, so in_ready follows out_ready through a single
// gate. The history is a chain of AVERAGE_DEPTH cells that all shift once
// per sample; reset clears them, the sum and the integrator at once, so no
// clearing pass is needed. Register 0 is filter_shift (reset 4, zero turns
// smoothing off) and register 1 is motion_threshold (reset 100); write them
// only while the block is idle. cfg_ready is always high.
// ----------------------------------------------------------------------------
module pir_motion_detector_unit
	import pmd_pkg::*;
#(
	parameter int AVERAGE_DEPTH = 16
)(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [SAMPLE_W-1:0]  sample,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [SAMPLE_W-1:0]       filtered,
	output logic signed [SAMPLE_W-1:0]       average,
	output logic                             motion,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_DAT_W-1:0]        cfg_data
);

	localparam int SUM_W = SAMPLE_W + $clog2(AVERAGE_DEPTH);
	localparam int CMP_W = SAMPLE_W + 2;

	// configuration registers
	logic [SHIFT_W-1:0] filter_shift_q;
	logic [THR_W-1:0]   motion_threshold_q;

	// pipeline state
	logic signed [ACC_W-1:0]    integrator_q;
	logic signed [ACC_W-1:0]    acc_next;
	logic signed [ACC_W-1:0]    acc_s1;
	logic                       vld_s1;
	logic                       vld_s2;
	logic                       vld_s3;
	logic signed [ACC_W-1:0]    acc_shifted;
	logic signed [SAMPLE_W-1:0] filt;
	logic signed [SAMPLE_W-1:0] filt_s2;
	logic signed [SAMPLE_W-1:0] filt_s3;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SAMPLE_W-1:0] avg;
	logic                       adv;
	logic                       accept;
	stage_ctl_t                 hist_ctl;
	stage_ctl_t                 div_ctl;

	// compare
	logic signed [CMP_W-1:0] f_ext;
	logic signed [CMP_W-1:0] a_ext;
	logic signed [CMP_W-1:0] t_ext;
	logic                    motion_next;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] filtered_q;
	logic signed [SAMPLE_W-1:0] average_q;
	logic                       motion_q;

	// advance everything when the output slot is free or being emptied
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign accept    = in_valid & adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_shift_q     <= FILTER_SHIFT_RST;
			motion_threshold_q <= MOTION_THRESHOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FILTER_SHIFT: begin
					filter_shift_q <= cfg_data[SHIFT_W-1:0];
				end
				REG_MOTION_THRESHOLD: begin
					motion_threshold_q <= cfg_data[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Stage 1: leaky integrator. With a zero shift the old value cancels and
	// the sample passes straight through.
	assign acc_next = integrator_q + ACC_W'(sample) - (integrator_q >>> filter_shift_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integrator_q <= '0;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
		end else if (adv) begin
			if (in_valid) begin
				integrator_q <= acc_next;
			end
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_s1 <= acc_next;
		end
	end

	// Stage 2: scale down and saturate; a shift lowered after accumulating
	// can leave the 16-bit range
	assign acc_shifted = acc_s1 >>> filter_shift_q;

	always_comb begin
		if (acc_shifted[ACC_W-1:SAMPLE_W-1] == '0
			|| acc_shifted[ACC_W-1:SAMPLE_W-1] == '1) begin
			filt = acc_shifted[SAMPLE_W-1:0];
		end else if (acc_shifted[ACC_W-1]) begin
			filt = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			filt = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	assign hist_ctl.adv = adv;
	assign hist_ctl.vld = vld_s1;

	pmd_history #(
		.DEPTH (AVERAGE_DEPTH),
		.SUM_W (SUM_W)
	) u_history (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hist_ctl),
		.filt   (filt),
		.sum    (sum)
	);

	// Stage 3: the sum in the history stays put while its item sits in
	// stage 2, so it feeds the divider directly
	assign div_ctl.adv = adv;
	assign div_ctl.vld = vld_s2;

	pmd_avg_div #(
		.DEPTH (AVERAGE_DEPTH),
		.SUM_W (SUM_W)
	) u_avg_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.sum    (sum),
		.avg    (avg)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (vld_s1) begin
				filt_s2 <= filt;
			end
			if (vld_s2) begin
				filt_s3 <= filt_s2;
			end
		end
	end

	// Stage 4: compare at a width where average +/- threshold never wraps
	assign f_ext = CMP_W'(filt_s3);
	assign a_ext = CMP_W'(avg);
	assign t_ext = CMP_W'({1'b0, motion_threshold_q});

	assign motion_next = (f_ext > a_ext + t_ext) || (f_ext < a_ext - t_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s3) begin
			filtered_q <= filt_s3;
			average_q  <= avg;
			motion_q   <= motion_next;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign average   = average_q;
	assign motion    = motion_q;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the PIR motion detector
// Walks a short table of directed samples, then ten random phases under
// changing filter shift and threshold. A local tracker of the integrator,
// history ring and running sum predicts every untyped result. Both handshakes idle
// and stall at random, and one long output hold-off backs up the pipeline.
// ----------------------------------------------------------------------------
module testbench;
	import pmd_pkg::*;

	localparam int AVG_DEPTH    = 16;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 163;
	localparam int HOLD_AT      = 420;   // results seen before the long hold-off
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer
	localparam int DRAIN_CYCLES = 12;
	localparam int PLAN_LEN     = 26;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic signed [SAMPLE_W-1:0] average;
		logic                       motion;
	} reading_t;

	// one directed sample plus the register settings it runs under
	typedef struct packed {
		logic [SHIFT_W-1:0]         shift;
		logic [THR_W-1:0]           thr;
		logic signed [SAMPLE_W-1:0] smp;
		logic                       typed;
		reading_t                   want;
	} plan_row_t;

	typedef enum int {ST_SCENE, ST_UNIFORM, ST_EXTREME, ST_RUNS} sample_style_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_mode_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [SAMPLE_W-1:0] filtered;
	logic signed [SAMPLE_W-1:0] average;
	logic                       motion;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DAT_W-1:0]       cfg_data;

	// tracker state: integrator, history ring and its exact sum
	logic signed [ACC_W-1:0]    integ;
	logic signed [SAMPLE_W-1:0] hist [AVG_DEPTH];
	longint                     hist_sum;
	int                         hist_pos;
	logic [SHIFT_W-1:0]         cur_shift;
	logic [THR_W-1:0]           cur_thr;

	reading_t due_readings [$];
	int       errors;
	int       n_results;
	int       burst_left;
	logic     steady;
	logic     held;
	int       base_level;
	int       run_left;
	int       run_val;

	// Directed table. Only the first rows after reset carry a typed result;
	// the rest go through the tracker. Rows walk: reset settings, the bypass
	// with negative samples, the largest threshold while the integrator
	// builds up, then a lowered shift so filtered saturates both ways.
	plan_row_t plan [PLAN_LEN] = '{
		'{4'd4,  15'd100,   16'sh0000, 1'b1, '{16'sh0000, 16'sh0000, 1'b0}},
		'{4'd4,  15'd100,   16'sh0000, 1'b1, '{16'sh0000, 16'sh0000, 1'b0}},
		'{4'd4,  15'd100,   16'sh7FFF, 1'b0, '0},
		'{4'd4,  15'd100,   16'sh7FFF, 1'b0, '0},
		'{4'd4,  15'd100,   16'sh8000, 1'b0, '0},
		'{4'd4,  15'd100,   16'shFFFF, 1'b0, '0},
		'{4'd4,  15'd100,   16'sh0001, 1'b0, '0},
		'{4'd0,  15'd0,     16'sh8000, 1'b0, '0},
		'{4'd0,  15'd0,     16'sh7FFF, 1'b0, '0},
		'{4'd0,  15'd0,     16'shFFFF, 1'b0, '0},
		'{4'd0,  15'd0,     16'sh0000, 1'b0, '0},
		'{4'd0,  15'd0,     16'sh0001, 1'b0, '0},
		'{4'd8,  15'h7FFF,  16'sh7FFF, 1'b0, '0},
		'{4'd8,  15'h7FFF,  16'sh7FFF, 1'b0, '0},
		'{4'd8,  15'h7FFF,  16'sh7FFF, 1'b0, '0},
		'{4'd8,  15'h7FFF,  16'sh7FFF, 1'b0, '0},
		'{4'd8,  15'h7FFF,  16'sh7FFF, 1'b0, '0},
		'{4'd1,  15'h7FFF,  16'sh7FFF, 1'b0, '0},
		'{4'd1,  15'h7FFF,  16'sh7FFF, 1'b0, '0},
		'{4'd8,  15'd5,     16'sh8000, 1'b0, '0},
		'{4'd8,  15'd5,     16'sh8000, 1'b0, '0},
		'{4'd8,  15'd5,     16'sh8000, 1'b0, '0},
		'{4'd8,  15'd5,     16'sh8000, 1'b0, '0},
		'{4'd8,  15'd5,     16'sh8000, 1'b0, '0},
		'{4'd8,  15'd5,     16'sh8000, 1'b0, '0},
		'{4'd1,  15'd5,     16'sh8000, 1'b0, '0}
	};

	pir_motion_detector_unit #(
		.AVERAGE_DEPTH(AVG_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.filtered  (filtered),
		.average   (average),
		.motion    (motion),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Advance the tracker by one sample and return the reading it implies.
	function automatic reading_t track_sample(input logic signed [SAMPLE_W-1:0] s);
		longint   acc;
		longint   filt;
		longint   avg;
		longint   thr;
		reading_t r;
		acc   = longint'(integ) + longint'(s) - longint'(integ >>> cur_shift);
		integ = acc[ACC_W-1:0];
		filt  = longint'(integ >>> cur_shift);
		// a shift lowered after accumulation can push filtered out of range
		if (filt > 32767)
			filt = 32767;
		else if (filt < -32768)
			filt = -32768;
		hist_sum = hist_sum - longint'(hist[hist_pos]) + filt;
		hist[hist_pos] = filt[SAMPLE_W-1:0];
		hist_pos = (hist_pos + 1) % AVG_DEPTH;
		avg = hist_sum / AVG_DEPTH;  // truncates toward zero
		thr = longint'(cur_thr);
		r.filtered = filt[SAMPLE_W-1:0];
		r.average  = avg[SAMPLE_W-1:0];
		r.motion   = (filt > avg + thr) || (filt < avg - thr);
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_style_t st);
		int v;
		v = 0;
		case (st)
			ST_SCENE: begin
				// quiet baseline with small noise, rare steps and person-sized spikes
				if ($urandom_range(0, 24) == 0)
					base_level = int'($urandom_range(0, 40000)) - 20000;
				if ($urandom_range(0, 29) == 0)
					v = base_level + int'($urandom_range(0, 60000)) - 30000;
				else
					v = base_level + int'($urandom_range(0, 128)) - 64;
			end
			ST_UNIFORM: v = int'($urandom_range(0, 65535)) - 32768;
			ST_EXTREME: begin
				case ($urandom_range(0, 5))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					3: v = -1;
					4: v = 1;
					default: v = int'($urandom_range(0, 65535)) - 32768;
				endcase
			end
			default: begin
				// constant runs settle the ring on one value
				if (run_left == 0) begin
					run_left = $urandom_range(1, 40);
					run_val  = int'($urandom_range(0, 65535)) - 32768;
				end
				run_left--;
				v = run_val;
			end
		endcase
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return v[SAMPLE_W-1:0];
	endfunction

	// Offer one sample and hold it until the transfer. Bursts of random
	// length are separated by random gaps, unless the phase runs steady.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic typed,
			input reading_t want);
		int       gap;
		reading_t got;
		gap = 0;
		if (!steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = $urandom_range(0, 12);
			end
			burst_left--;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		got = track_sample(s);
		due_readings.push_back(typed ? want : got);
	endtask

	// Drop valid in the step of the last transfer, then wait out every result.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (due_readings.size() != 0)
			@(posedge clk);
	endtask

	// Write both registers back to back; track each at its own transfer.
	task automatic write_regs(input logic [CFG_DAT_W-1:0] shift_word,
			input logic [CFG_DAT_W-1:0] thr_word);
		cfg_valid <= 1'b1;
		cfg_index <= REG_FILTER_SHIFT;
		cfg_data  <= shift_word;
		do @(posedge clk); while (!cfg_ready);
		cur_shift = shift_word[SHIFT_W-1:0];
		cfg_index <= REG_MOTION_THRESHOLD;
		cfg_data  <= thr_word;
		do @(posedge clk); while (!cfg_ready);
		cur_thr = thr_word[THR_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	// Compare each result transfer with the oldest pending reading.
	always @(posedge clk) begin : result_check
		reading_t w;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (due_readings.size() == 0) begin
				$display("%0t: result with none pending: filtered %0d average %0d motion %0d",
					$time, filtered, average, motion);
				errors++;
			end else begin
				w = due_readings.pop_front();
				if (filtered !== w.filtered) begin
					$display("%0t: filtered mismatch: expected %0d, actual %0d",
						$time, $signed(w.filtered), filtered);
					errors++;
				end
				if (average !== w.average) begin
					$display("%0t: average mismatch: expected %0d, actual %0d",
						$time, $signed(w.average), average);
					errors++;
				end
				if (motion !== w.motion) begin
					$display("%0t: motion mismatch: expected %0d, actual %0d",
						$time, w.motion, motion);
					errors++;
				end
			end
		end
	end

	// Receiver: windows of random length, each with its own stall pattern.
	// Once, hold off for a long stretch so the pipeline fills and stalls.
	initial begin : receiver
		int       window;
		int       tick;
		rx_mode_t mode;
		window = 0;
		tick   = 0;
		mode   = RX_OPEN;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			tick++;
			if (!held && n_results >= HOLD_AT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (window == 0) begin
					window = $urandom_range(50, 300);
					mode   = rx_mode_t'($urandom_range(0, 3));
				end
				window--;
				case (mode)
					RX_OPEN:    out_ready <= 1'b1;
					RX_COIN:    out_ready <= ($urandom_range(0, 1) == 1);
					RX_PATTERN: out_ready <= ((tick % 7) > 1);
					default:    out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("pir_motion_detector_unit regression: fail");
		$finish;
	end

	initial begin : stimulus
		int                         i;
		int                         p;
		int                         j;
		logic [SHIFT_W-1:0]         shift;
		logic [THR_W-1:0]           thr;
		sample_style_t              style;
		logic signed [SAMPLE_W-1:0] s;
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		sample     = '0;
		out_ready  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_FILTER_SHIFT;
		cfg_data   = '0;
		errors     = 0;
		n_results  = 0;
		burst_left = 0;
		steady     = 1'b0;
		held       = 1'b0;
		base_level = 0;
		run_left   = 0;
		run_val    = 0;
		integ      = '0;
		hist_sum   = 0;
		hist_pos   = 0;
		cur_shift  = FILTER_SHIFT_RST;
		cur_thr    = MOTION_THRESHOLD_RST;
		for (i = 0; i < AVG_DEPTH; i++)
			hist[i] = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: rewrite the registers only where a row changes them
		for (i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].shift != cur_shift || plan[i].thr != cur_thr) begin
				drain_pipeline();
				write_regs(CFG_DAT_W'(plan[i].shift), CFG_DAT_W'(plan[i].thr));
			end
			send_sample(plan[i].smp, plan[i].typed, plan[i].want);
		end

		// random phases: force the register extremes in the first four
		for (p = 0; p < PHASES; p++) begin
			drain_pipeline();
			shift = (p == 0) ? 4'd0 : (p == 1) ? 4'd15 : SHIFT_W'($urandom_range(0, 15));
			thr   = (p == 2) ? 15'd0 : (p == 3) ? 15'h7FFF : THR_W'($urandom_range(0, 3000));
			// upper data bits of the shift write are don't-care; toggle them
			write_regs({(CFG_DAT_W - SHIFT_W)'($urandom), shift}, thr);
			steady = (p == 5);
			style  = sample_style_t'(p % 4);
			for (j = 0; j < PHASE_ITEMS; j++) begin
				s = pick_sample(style);
				send_sample(s, 1'b0, '0);
			end
		end

		drain_pipeline();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("pir_motion_detector_unit regression: pass");
		else
			$display("pir_motion_detector_unit regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/pmd_pkg.sv
rtl/core/pmd_cell.sv
rtl/core/pmd_history.sv
rtl/core/pmd_avg_div.sv
rtl/core/pir_motion_detector_unit.sv
test/testbench.sv
